// File: rtl/core/fenwick_prefix_sum_engine_assert.svh
// Assertion macros of the prefix-sum engine RTL, used by the datapath.
// Needs aclk and aresetn in the scope of each use.
`ifndef FENWICK_PREFIX_SUM_ENGINE_ASSERT_SVH
`define FENWICK_PREFIX_SUM_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/fps_pkg.sv
// Shared types and constants of the prefix-sum engine.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package fps_pkg;

    localparam int DEPTH  = 1024;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int N_W    = IDX_W + 1;
    localparam int SIZE_W = 11;
    localparam int DATA_W = 64;
    localparam int CMD_W  = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_POINT_ADD   = 2'd0,
        CMD_RANGE_ADD   = 2'd1,
        CMD_PREFIX_SUM  = 2'd2,
        CMD_RANGE_SUM   = 2'd3
    } cmd_t;

    // Which walk to start, with its start slot and direction.
    typedef enum logic [1:0] {
        WS_LO_ADD   = 2'd0,
        WS_HI1_ADD  = 2'd1,
        WS_HI_SUM   = 2'd2,
        WS_LOM1_SUB = 2'd3
    } walk_sel_t;

    typedef struct packed {
        logic      clr_en;
        logic      load;
        logic      walk_start;
        walk_sel_t walk_sel;
        logic      rd_en;
        logic      apply;
        logic      out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic walk_done;
        logic bad;
        cmd_t cmd;
        logic lo_zero;
        logic out_free;
    } dp_status_t;

endpackage

// File: rtl/core/fenwick_prefix_sum_engine.sv
// Top level of the binary indexed tree prefix-sum engine.
// Depends on fps_pkg, fps_ctrl and fps_datapath.
//
//  Channel   Direction  Handshake             Contents
//  s_        in         s_tvalid / s_tready   one command item (tuser: cmd, tdata: operands)
//  m_        out        m_tvalid / m_tready   one result item (tuser: status, tdata: sum)
//  cfg_      in         cfg_valid / cfg_ready size_in_use register, always ready
//
// An item runs from acceptance through a decide step and then, for each tree slot visited, a
// registered read and then a write or an accumulate on the store; a range item may run a
// second walk, and an error result goes from the decide step to the result register. A walk
// visits at most log2(DEPTH) slots. After reset a clearing pass zeroes all DEPTH (1024)
// slots of the store before the first item is accepted; configuration writes are taken
// throughout. A result waits in the output register while the next item runs. The input is
// ready only while the engine is idle, and an item also waits when its result is ready
// before the previous result has been taken.
`timescale 1ns / 1ps

module fenwick_prefix_sum_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Command items.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [1:0]                    s_tuser,   // [1:0] cmd
    input  logic [87:0]                   s_tdata,   // [9:0] first_index, [19:10]
                                                     // last_index, [83:20] delta, zero pad
    // Result items.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [0:0]                    m_tuser,   // [0] status
    output logic [63:0]                   m_tdata,   // [63:0] sum
    // Size register writes.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fps_pkg::SIZE_W-1:0]    cfg_data
);

    fps_pkg::ctrl_cmd_t  ctrl;
    fps_pkg::dp_status_t stat;
    fps_pkg::cmd_t       in_cmd;

    // The register may be written whenever the engine is idle, so the port is always ready.
    assign cfg_ready = 1'b1;
    assign in_cmd    = fps_pkg::cmd_t'(s_tuser);

    fps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    fps_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .stat       (stat),
        .in_cmd     (in_cmd),
        .in_first   (s_tdata[9:0]),
        .in_last    (s_tdata[19:10]),
        .in_delta   (s_tdata[83:20]),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_size   (cfg_data),
        .out_sum    (m_tdata),
        .out_status (m_tuser[0]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready)
    );

endmodule

// File: rtl/core/fps_datapath.sv
// Datapath of the prefix-sum engine: tree store, walk index, accumulator,
// size register and result register. Depends on fps_pkg and the assert header.
`timescale 1ns / 1ps

`include "fenwick_prefix_sum_engine_assert.svh"

module fps_datapath (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  fps_pkg::ctrl_cmd_t        ctrl,
    output fps_pkg::dp_status_t       stat,
    input  fps_pkg::cmd_t             in_cmd,
    input  logic [fps_pkg::IDX_W-1:0] in_first,
    input  logic [fps_pkg::IDX_W-1:0] in_last,
    input  logic [fps_pkg::DATA_W-1:0] in_delta,
    input  logic                      cfg_we,
    input  logic [fps_pkg::SIZE_W-1:0] cfg_size,
    output logic [fps_pkg::DATA_W-1:0] out_sum,
    output logic                      out_status,
    output logic                      out_valid,
    input  logic                      out_ready
);

    logic [fps_pkg::DATA_W-1:0] mem [fps_pkg::DEPTH];

    fps_pkg::cmd_t              cmd_reg;
    logic [fps_pkg::IDX_W-1:0]  lo_reg, hi_reg;
    logic [fps_pkg::DATA_W-1:0] delta_reg;
    logic [fps_pkg::N_W-1:0]    n_reg, n_next;
    logic [fps_pkg::N_W-1:0]    k_reg, k_next;
    logic [fps_pkg::DATA_W-1:0] amt_reg, amt_next;
    logic                       up_reg, up_next;
    logic                       sub_reg, sub_next;
    logic [fps_pkg::DATA_W-1:0] acc_reg, acc_next;
    logic [fps_pkg::DATA_W-1:0] rd_data_reg;
    logic [fps_pkg::DATA_W-1:0] sum_out_reg;
    logic                       status_out_reg;
    logic                       out_valid_reg, out_valid_next;
    logic [fps_pkg::SIZE_W-1:0] size_reg, size_next;
    logic [fps_pkg::IDX_W-1:0]  clr_cnt_reg, clr_cnt_next;

    logic [fps_pkg::N_W-1:0]    lo_ext, hi_ext, low_bit;
    logic                       bad;
    logic                       wr_en;
    logic [fps_pkg::IDX_W-1:0]  wr_addr;
    logic [fps_pkg::DATA_W-1:0] wr_data;

    assign lo_ext  = {1'b0, lo_reg};
    assign hi_ext  = {1'b0, hi_reg};
    assign low_bit = k_reg & (~k_reg + fps_pkg::N_W'(1));

    always_comb begin
        case (cmd_reg)
            fps_pkg::CMD_POINT_ADD:  bad = (lo_reg == '0) || (lo_ext >= n_reg);
            fps_pkg::CMD_RANGE_ADD:  bad = (lo_reg == '0) || (hi_reg < lo_reg) ||
                                           (hi_ext >= n_reg);
            fps_pkg::CMD_PREFIX_SUM: bad = (hi_ext >= n_reg);
            fps_pkg::CMD_RANGE_SUM:  bad = (lo_reg > hi_reg) || (hi_ext >= n_reg);
            default:                 bad = 1'b1;
        endcase
    end

    // Effective size saturates at the store depth.
    always_comb begin
        if (size_reg > fps_pkg::SIZE_W'(fps_pkg::DEPTH)) begin
            n_next = fps_pkg::N_W'(fps_pkg::DEPTH);
        end else begin
            n_next = fps_pkg::N_W'(size_reg);
        end
    end

    always_comb begin
        k_next   = k_reg;
        amt_next = amt_reg;
        up_next  = up_reg;
        sub_next = sub_reg;
        acc_next = acc_reg;
        if (ctrl.load) begin
            acc_next = '0;
        end else if (ctrl.walk_start) begin
            case (ctrl.walk_sel)
                fps_pkg::WS_LO_ADD: begin
                    k_next   = lo_ext;
                    amt_next = delta_reg;
                    up_next  = 1'b1;
                end
                fps_pkg::WS_HI1_ADD: begin
                    k_next   = hi_ext + fps_pkg::N_W'(1);
                    amt_next = '0 - delta_reg;
                    up_next  = 1'b1;
                end
                fps_pkg::WS_HI_SUM: begin
                    k_next   = hi_ext;
                    up_next  = 1'b0;
                    sub_next = 1'b0;
                end
                fps_pkg::WS_LOM1_SUB: begin
                    k_next   = lo_ext - fps_pkg::N_W'(1);
                    up_next  = 1'b0;
                    sub_next = 1'b1;
                end
                default: begin
                    k_next = k_reg;
                end
            endcase
        end else if (ctrl.apply) begin
            if (up_reg) begin
                k_next = k_reg + low_bit;
            end else begin
                k_next = k_reg - low_bit;
                if (sub_reg) begin
                    acc_next = acc_reg - rd_data_reg;
                end else begin
                    acc_next = acc_reg + rd_data_reg;
                end
            end
        end
    end

    always_comb begin
        size_next      = cfg_we ? cfg_size : size_reg;
        clr_cnt_next   = ctrl.clr_en ? clr_cnt_reg + fps_pkg::IDX_W'(1) : clr_cnt_reg;
        out_valid_next = ctrl.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg      <= fps_pkg::SIZE_W'(fps_pkg::DEPTH);
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            size_reg      <= size_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            cmd_reg   <= in_cmd;
            lo_reg    <= in_first;
            hi_reg    <= in_last;
            delta_reg <= in_delta;
            n_reg     <= n_next;
        end
        k_reg   <= k_next;
        amt_reg <= amt_next;
        up_reg  <= up_next;
        sub_reg <= sub_next;
        acc_reg <= acc_next;
        if (ctrl.out_load) begin
            sum_out_reg    <= bad ? '0 : acc_reg;
            status_out_reg <= bad;
        end
    end

    // Tree store: one write port shared by the clearing pass and the add walks.
    assign wr_en   = ctrl.clr_en || (ctrl.apply && up_reg);
    assign wr_addr = ctrl.clr_en ? clr_cnt_reg : k_reg[fps_pkg::IDX_W-1:0];
    assign wr_data = ctrl.clr_en ? '0 : rd_data_reg + amt_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (ctrl.rd_en) begin
            rd_data_reg <= mem[k_reg[fps_pkg::IDX_W-1:0]];
        end
    end

    always_comb begin
        stat.clr_last  = (clr_cnt_reg == fps_pkg::IDX_W'(fps_pkg::DEPTH - 1));
        stat.walk_done = up_reg ? (k_reg >= n_reg) : (k_reg == '0);
        stat.bad       = bad;
        stat.cmd       = cmd_reg;
        stat.lo_zero   = (lo_reg == '0);
        stat.out_free  = !out_valid_reg || out_ready;
    end

    assign out_sum    = sum_out_reg;
    assign out_status = status_out_reg;
    assign out_valid  = out_valid_reg;

    `FPS_ASSERT_SAME(a_wr_only_up, wr_en && !ctrl.clr_en, up_reg && (k_reg < n_reg), "store written outside an upward walk")
    `FPS_ASSERT_SAME(a_rd_live_slot, ctrl.rd_en, (k_reg != '0) && (!up_reg || (k_reg < n_reg)), "read of a slot the walk has left")
    `FPS_ASSERT_NEXT(a_err_zero_sum, ctrl.out_load && bad, (sum_out_reg == '0) && status_out_reg, "error result with a nonzero sum")

endmodule

// File: rtl/core/fps_ctrl.sv
// Controller of the prefix-sum engine: clearing pass, walk sequencing, result hand-off.
// Depends on fps_pkg; drives the datapath through ctrl_cmd_t.
`timescale 1ns / 1ps

module fps_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  fps_pkg::dp_status_t stat,
    output fps_pkg::ctrl_cmd_t  ctrl
);

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_DECIDE = 6'b000100,
        ST_WALK   = 6'b001000,
        ST_APPLY  = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   second_reg, second_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next      = state_reg;
        second_next     = second_reg;
        ctrl            = '0;
        ctrl.walk_sel   = fps_pkg::WS_LO_ADD;
        case (state_reg)
            ST_CLEAR: begin
                ctrl.clr_en = 1'b1;
                if (stat.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_valid) begin
                    ctrl.load  = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (stat.bad) begin
                    state_next = ST_DONE;
                end else begin
                    ctrl.walk_start = 1'b1;
                    state_next      = ST_WALK;
                    case (stat.cmd)
                        fps_pkg::CMD_POINT_ADD: begin
                            ctrl.walk_sel = fps_pkg::WS_LO_ADD;
                            second_next   = 1'b0;
                        end
                        fps_pkg::CMD_RANGE_ADD: begin
                            ctrl.walk_sel = fps_pkg::WS_LO_ADD;
                            second_next   = 1'b1;
                        end
                        fps_pkg::CMD_PREFIX_SUM: begin
                            ctrl.walk_sel = fps_pkg::WS_HI_SUM;
                            second_next   = 1'b0;
                        end
                        default: begin
                            ctrl.walk_sel = fps_pkg::WS_HI_SUM;
                            second_next   = !stat.lo_zero;
                        end
                    endcase
                end
            end
            ST_WALK: begin
                if (stat.walk_done) begin
                    if (second_reg) begin
                        ctrl.walk_start = 1'b1;
                        ctrl.walk_sel   = (stat.cmd == fps_pkg::CMD_RANGE_ADD) ?
                                          fps_pkg::WS_HI1_ADD : fps_pkg::WS_LOM1_SUB;
                        second_next     = 1'b0;
                    end else begin
                        state_next = ST_DONE;
                    end
                end else begin
                    ctrl.rd_en = 1'b1;
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                ctrl.apply = 1'b1;
                state_next = ST_WALK;
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    ctrl.out_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            second_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            second_reg <= second_next;
        end
    end

endmodule

// File: verif/fenwick_prefix_sum_engine_tb.sv
// Self-checking testbench for the binary indexed tree prefix-sum engine.
// It needs fps_pkg and fenwick_prefix_sum_engine. A tracker class holds its own copy of the
// tree and predicts each result. Tasks drive the command and size channels, a process the result side.
`timescale 1ns / 1ps

module fenwick_prefix_sum_engine_tb;
    import fps_pkg::*;

    localparam int unsigned LONG_HOLD      = 400;
    localparam int unsigned TAIL_CYCLES    = 64;
    localparam int unsigned WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic        status;
        logic [63:0] sum;
    } sum_result_t;

    // Keeps a private copy of the tree and of the size register. It queues
    // the result that each accepted command item must produce.
    class fenwick_sum_tracker;
        logic [63:0]      nodes [DEPTH];
        logic [SIZE_W-1:0] size_reg;
        sum_result_t      pending_sums [$];

        function new();
            foreach (nodes[i]) nodes[i] = '0;
            size_reg = SIZE_W'(DEPTH);
        endfunction

        function void set_size(logic [SIZE_W-1:0] value);
            size_reg = value;
        endfunction

        // Sizes above the store depth saturate to the depth.
        function int unsigned active_size();
            return (size_reg > DEPTH) ? DEPTH : size_reg;
        endfunction

        function int unsigned pending();
            return pending_sums.size();
        endfunction

        // Upward walk: each step adds the lowest set bit of the slot number.
        function void climb_add(int unsigned slot, logic [63:0] amount);
            int unsigned n;
            n = active_size();
            while (slot != 0 && slot < n) begin
                nodes[slot] += amount;
                slot += slot & (~slot + 1);
            end
        endfunction

        // Downward walk: each step clears the lowest set bit.
        function logic [63:0] descend_sum(int unsigned slot);
            logic [63:0] acc;
            acc = '0;
            while (slot != 0) begin
                if (slot < DEPTH) acc += nodes[slot];
                slot -= slot & (~slot + 1);
            end
            return acc;
        endfunction

        function void note_command(cmd_t op, logic [9:0] lo, logic [9:0] hi,
                                   logic [63:0] delta);
            int unsigned n;
            int unsigned a;
            int unsigned b;
            sum_result_t r;
            n = active_size();
            a = lo;
            b = hi;
            r.sum = '0;
            r.status = 1'b0;
            case (op)
                CMD_POINT_ADD: begin
                    if (a == 0 || a >= n) r.status = 1'b1;
                    else climb_add(a, delta);
                end
                CMD_RANGE_ADD: begin
                    if (a == 0 || b < a || b >= n) begin
                        r.status = 1'b1;
                    end else begin
                        climb_add(a, delta);
                        // At the top slot the walk ends at once, which drops the negation.
                        climb_add(b + 1, 64'd0 - delta);
                    end
                end
                CMD_PREFIX_SUM: begin
                    if (b >= n) r.status = 1'b1;
                    else r.sum = descend_sum(b);
                end
                CMD_RANGE_SUM: begin
                    if (a > b || b >= n) begin
                        r.status = 1'b1;
                    end else begin
                        r.sum = descend_sum(b);
                        if (a != 0) r.sum -= descend_sum(a - 1);
                    end
                end
            endcase
            pending_sums.push_back(r);
        endfunction

        // Returns an empty string when the result matches the oldest expectation.
        function string check_result(logic status, logic [63:0] sum);
            sum_result_t want;
            string msg;
            if (pending_sums.size() == 0)
                return $sformatf("unexpected result: status %0d sum %h", status, sum);
            want = pending_sums.pop_front();
            msg = "";
            if (want.status !== status)
                msg = $sformatf("status %0d, expected %0d; ", status, want.status);
            if (want.sum !== sum)
                msg = {msg, $sformatf("sum %h, expected %h", sum, want.sum)};
            return msg;
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [1:0]          s_tuser;
    logic [87:0]         s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [0:0]          m_tuser;
    logic [63:0]         m_tdata;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [SIZE_W-1:0]   cfg_data;

    fenwick_sum_tracker  tracker = new();
    int unsigned         mismatches = 0;
    bit                  steady_flow = 1'b0;
    bit                  hold_off_request = 1'b0;

    fenwick_prefix_sum_engine uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [9:0] pick_index(int unsigned n);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (n < 2 || r == 0) return 10'($urandom_range(0, 1023));
        if (r == 1) return 10'(n - 1);
        if (r == 2) return 10'd1;
        if (r == 3) return 10'd0;
        return 10'($urandom_range(1, n - 1));
    endfunction

    task automatic send_cmd(cmd_t op, logic [9:0] lo, logic [9:0] hi, logic [63:0] delta);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0000, delta, hi, lo};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        tracker.note_command(op, lo, hi, delta);
    endtask

    task automatic sender_pause(int unsigned cycles);
        if (cycles != 0) begin
            s_tvalid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    // Stops offering items until every outstanding result has been taken.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (tracker.pending() != 0);
    endtask

    task automatic write_size(logic [SIZE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        tracker.set_size(value);
    endtask

    task automatic random_cmd(output cmd_t op, output logic [9:0] lo, output logic [9:0] hi,
                              output logic [63:0] delta);
        int unsigned n;
        logic [9:0] t;
        n = tracker.active_size();
        op = cmd_t'($urandom_range(0, 3));
        lo = pick_index(n);
        hi = pick_index(n);
        // Keep most ranges well ordered so that they reach the tree walks.
        if (lo > hi && $urandom_range(0, 7) != 0) begin
            t = lo;
            lo = hi;
            hi = t;
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: delta = 64'($urandom_range(0, 2000)) - 64'd1000;
            6, 7, 8:          delta = {$urandom, $urandom};
            default: begin
                case ($urandom_range(0, 3))
                    0:       delta = 64'h7FFF_FFFF_FFFF_FFFF;
                    1:       delta = 64'h8000_0000_0000_0000;
                    2:       delta = '1;
                    default: delta = '0;
                endcase
            end
        endcase
    endtask

    // One run of random items at a given size, with a full drain before it, midway and at random.
    task automatic run_phase(logic [SIZE_W-1:0] size, int unsigned count, bit steady,
                             bit long_hold);
        cmd_t op;
        logic [9:0] lo;
        logic [9:0] hi;
        logic [63:0] delta;
        drain_results();
        write_size(size);
        steady_flow = steady;
        if (long_hold) hold_off_request = 1'b1;
        for (int unsigned i = 0; i < count; i++) begin
            random_cmd(op, lo, hi, delta);
            send_cmd(op, lo, hi, delta);
            if (i == count / 2 || $urandom_range(0, 63) == 0) drain_results();
            else if (!steady) sender_pause(pick_gap());
        end
    endtask

    // Result side: checks every accepted result and stalls at random outside steady phases.
    initial begin : result_sink
        int unsigned stall_left;
        string verdict;
        stall_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                verdict = tracker.check_result(m_tuser[0], m_tdata);
                if (verdict != "") report_mismatch(verdict);
            end
            if (hold_off_request) begin
                // A long hold-off lets the engine fill up and stall its input.
                hold_off_request = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (stall_left != 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (!steady_flow && $urandom_range(0, 2) == 0) stall_left = pick_gap();
            end
        end
    end

    // Ends the run when no handshake of any channel happens for too long.
    initial begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[%0t] timeout: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= '0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed items at full size; the first waits out the clearing pass.
        write_size(11'd1024);
        send_cmd(CMD_PREFIX_SUM, 10'd0,    10'd1023, 64'd0);
        send_cmd(CMD_POINT_ADD,  10'd0,    10'd0,    64'd7);
        send_cmd(CMD_POINT_ADD,  10'd1,    10'd0,    64'h7FFF_FFFF_FFFF_FFFF);
        send_cmd(CMD_POINT_ADD,  10'd1023, 10'd1023, 64'h8000_0000_0000_0000);
        send_cmd(CMD_POINT_ADD,  10'd512,  10'd3,    '1);
        send_cmd(CMD_PREFIX_SUM, 10'd1023, 10'd0,    '1);
        send_cmd(CMD_PREFIX_SUM, 10'd0,    10'd1023, 64'd0);
        send_cmd(CMD_RANGE_ADD,  10'd0,    10'd9,    64'd3);
        send_cmd(CMD_RANGE_ADD,  10'd10,   10'd5,    64'd3);
        send_cmd(CMD_RANGE_ADD,  10'd1,    10'd1023, 64'd5);
        send_cmd(CMD_RANGE_ADD,  10'd3,    10'd700,  64'h5555_5555_5555_5555);
        send_cmd(CMD_RANGE_SUM,  10'd5,    10'd4,    64'd0);
        send_cmd(CMD_RANGE_SUM,  10'd0,    10'd1023, 64'd0);
        send_cmd(CMD_RANGE_SUM,  10'd1,    10'd1,    64'd0);
        send_cmd(CMD_RANGE_SUM,  10'd700,  10'd701,  64'd0);
        send_cmd(CMD_POINT_ADD,  10'd1023, 10'd0,    64'd0);
        send_cmd(CMD_PREFIX_SUM, 10'd0,    10'd511,  64'd0);
        send_cmd(CMD_RANGE_SUM,  10'd1023, 10'd1023, 64'd0);

        // Directed index errors and the dropped top add at a small size.
        drain_results();
        write_size(11'd13);
        send_cmd(CMD_POINT_ADD,  10'd13,   10'd0,    64'd9);
        send_cmd(CMD_RANGE_ADD,  10'd3,    10'd13,   64'd9);
        send_cmd(CMD_PREFIX_SUM, 10'd0,    10'd13,   64'd0);
        send_cmd(CMD_RANGE_SUM,  10'd2,    10'd20,   64'd0);
        send_cmd(CMD_RANGE_ADD,  10'd4,    10'd12,   64'd11);
        send_cmd(CMD_PREFIX_SUM, 10'd0,    10'd12,   64'd0);

        // Random phases over several sizes, the extremes among them.
        run_phase(11'd1024, 200, 1'b0, 1'b1);
        run_phase(11'd13,   120, 1'b1, 1'b0);
        run_phase(11'd0,     25, 1'b0, 1'b0);
        run_phase(11'd2047, 150, 1'b0, 1'b1);
        run_phase(11'd1,     25, 1'b0, 1'b0);
        run_phase(11'd2,     30, 1'b1, 1'b0);
        run_phase(SIZE_W'($urandom_range(3, 1023)), 120, 1'b0, 1'b0);
        run_phase(11'd1023,  80, 1'b0, 1'b0);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
